[src/wstd_pkg.sv]
`default_nettype none

package wstd_pkg;

	// Action codes of an input word
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_STEAL = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept; // latch the input word and issue the entry read
		logic exec;   // apply the operation and load the result registers
	} cmd_t;

endpackage

`default_nettype wire

[src/wstd_ram.sv]
`default_nettype none

module wstd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[src/wstd_ctrl.sv]
`default_nettype none

module wstd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output wstd_pkg::cmd_t     cmd
);

	import wstd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy       = (state_q == S_EXEC);
	assign done       = (state_q == S_DONE);
	assign cmd.accept = start && !busy;
	assign cmd.exec   = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = cmd.accept ? S_EXEC : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.exec)
		else $error("accepted word not executed next cycle");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done && !cmd.exec)
		else $error("execute step not followed by result strobe");

	a_done_needs_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(cmd.exec))
		else $error("result strobe without execute step");

endmodule

`default_nettype wire

[src/wstd_dpath.sv]
`default_nettype none

module wstd_dpath #(
	parameter int DEPTH      = 256,
	parameter int TASK_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire wstd_pkg::cmd_t cmd,
	input  wire logic [1:0]     action,
	input  wire logic [31:0]    task_in,
	output logic      [31:0]    task_out,
	output logic                found,
	output logic                overflowed,
	output logic                now_empty
);

	import wstd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	logic [IW-1:0]         head_q, tail_q;
	logic                  empty_q;
	logic [1:0]            act_q;
	logic [TASK_WIDTH-1:0] word_q;

	logic [IW-1:0]         head_d, tail_d;
	logic                  empty_d;
	logic                  found_d, ovf_d;
	logic [31:0]           task_d;

	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [IW-1:0]         ram_raddr;
	logic [TASK_WIDTH-1:0] ram_rdata;

	logic [IW-1:0]         head_inc, head_dec, tail_inc, tail_dec;

	assign head_inc = (head_q == LAST) ? '0 : head_q + IW'(1);
	assign head_dec = (head_q == '0) ? LAST : head_q - IW'(1);
	assign tail_inc = (tail_q == LAST) ? '0 : tail_q + IW'(1);
	assign tail_dec = (tail_q == '0) ? LAST : tail_q - IW'(1);

	// Read the head slot, or the tail slot for a steal, as the word is taken
	assign ram_raddr = (action == ACT_STEAL) ? tail_q : head_q;

	wstd_ram #(
		.WIDTH (TASK_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (word_q),
		.re    (cmd.accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		empty_d   = empty_q;
		found_d   = 1'b0;
		ovf_d     = 1'b0;
		task_d    = '0;
		ram_we    = 1'b0;
		ram_waddr = head_dec;
		case (act_q)
			ACT_PUSH: begin
				if (empty_q) begin
					head_d    = LAST;
					tail_d    = LAST;
					empty_d   = 1'b0;
					ram_we    = cmd.exec;
					ram_waddr = LAST;
				end else if (tail_inc == head_q) begin
					ovf_d = 1'b1;
				end else begin
					head_d = head_dec;
					ram_we = cmd.exec;
				end
			end
			ACT_POP: begin
				if (!empty_q) begin
					task_d  = 32'(ram_rdata);
					found_d = 1'b1;
					if (head_q == tail_q) empty_d = 1'b1;
					else head_d = head_inc;
				end
			end
			ACT_STEAL: begin
				if (!empty_q) begin
					task_d  = 32'(ram_rdata);
					found_d = 1'b1;
					if (head_q == tail_q) empty_d = 1'b1;
					else tail_d = tail_dec;
				end
			end
			default: begin
				// unused code: leave the state alone
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q  <= action;
			word_q <= TASK_WIDTH'(task_in);
		end
		if (cmd.exec) begin
			task_out   <= task_d;
			found      <= found_d;
			overflowed <= ovf_d;
			now_empty  <= empty_d;
		end
	end

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && act_q == ACT_PUSH |=> !empty_q && !found)
		else $error("push left deque empty or reported a find");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && empty_q && (act_q == ACT_POP || act_q == ACT_STEAL)
		|=> !found && task_out == '0 && now_empty)
		else $error("take from empty deque returned an entry");

	a_flag_match: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.exec) |-> now_empty == empty_q && !(found && overflowed))
		else $error("result flags disagree with deque state");

endmodule

`default_nettype wire

[src/work_stealing_task_deque_top.sv]
// Work-stealing circular task deque. The owner pushes (action 0) and pops
// (action 1) descriptor words at the head end; a thief steals (action 2) at
// the tail end. A word is taken at a rising edge with start high and busy
// low. Every word yields one result, shown on task_out, found, overflowed
// and now_empty for exactly one cycle while done is high; the receiver has
// no way to stall it, so capture it on that cycle. For each word, the
// entry RAM read is issued as the word is taken, the operation is
// applied in the following execute cycle (busy high), and the result
// strobe follows, during which the next word may already be taken. While
// busy no word is taken, as the read of the entry RAM is registered. A
// push on a full deque is dropped with overflowed set; a pop or steal
// on an empty deque returns found low and task_out zero.
// The entry RAM needs no clearing after reset.
`default_nettype none

module work_stealing_task_deque_top #(
	parameter int DEPTH      = 256,
	parameter int TASK_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] task_in,
	output logic             done,
	output logic      [31:0] task_out,
	output logic             found,
	output logic             overflowed,
	output logic             now_empty
);

	import wstd_pkg::*;

	cmd_t cmd;

	// Sequence accept, execute and result strobe
	wstd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold pointers, empty flag, entry RAM and result registers
	wstd_dpath #(
		.DEPTH      (DEPTH),
		.TASK_WIDTH (TASK_WIDTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.task_in    (task_in),
		.task_out   (task_out),
		.found      (found),
		.overflowed (overflowed),
		.now_empty  (now_empty)
	);

endmodule

`default_nettype wire
